FILE: sv/gnva_pkg.sv
// shared types, codes and constants for the grouped nodal value averager
package gnva_pkg;

  localparam int DEF_GROUPS  = 4;
  localparam int DEF_NODES   = 1024;
  localparam int QUEUE_DEPTH = 2;

  localparam int VAL_W = 32;
  localparam int SUM_W = 40;
  localparam int CNT_W = 8;
  localparam int ENTRY_W = SUM_W + CNT_W;

  localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

  // request codes on req_type
  typedef enum logic [1:0] {
    REQ_ACCUM = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FILTERED = 2'd1;
  localparam logic [1:0] STAT_RANGE    = 2'd2;
  localparam logic [1:0] STAT_SAT      = 2'd3;

  // work kinds handed from front to back
  typedef enum logic [1:0] {
    KIND_EMIT  = 2'd0,
    KIND_ACCUM = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [VAL_W-1:0]   value;
    logic [1:0]         status;
  } cmd_t;

endpackage

FILE: sv/gnva_ram.sv
// generic single write port ram with registered read
module gnva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/gnva_front.sv
// front end: config register, request decode and range check
module gnva_front import gnva_pkg::*; #(
  parameter int GROUPS = DEF_GROUPS,
  parameter int NODES  = DEF_NODES,
  parameter int AW     = $clog2(GROUPS * NODES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_data,
  input  logic [1:0]       req_type,
  input  logic [7:0]       group_index,
  input  logic [15:0]      node_index,
  input  logic [VAL_W-1:0] entry_value,
  input  logic             entry_active,
  output cmd_t             cmd,
  output logic [AW-1:0]    cmd_addr
);

  logic only_active;
  logic in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      only_active <= 1'b0;
    end else if (cfg_we) begin
      only_active <= cfg_data;
    end
  end

  assign in_range = (32'(group_index) < 32'(GROUPS)) && (32'(node_index) < 32'(NODES));
  assign cmd_addr = AW'(32'(group_index) * 32'(NODES) + 32'(node_index));

  always_comb begin
    cmd.kind   = KIND_EMIT;
    cmd.value  = '0;
    cmd.status = STAT_OK;
    unique case (req_t'(req_type))
      REQ_CLEAR: begin
        cmd.kind = KIND_CLEAR;
      end
      REQ_NONE: begin
        cmd.kind = KIND_EMIT;
      end
      REQ_ACCUM, REQ_READ: begin
        priority if (only_active && !entry_active) begin
          cmd.value  = entry_value;
          cmd.status = STAT_FILTERED;
        end else if (!in_range) begin
          cmd.status = STAT_RANGE;
        end else begin
          cmd.kind  = (req_t'(req_type) == REQ_ACCUM) ? KIND_ACCUM : KIND_READ;
          cmd.value = entry_value;
        end
      end
      default: begin
        cmd.kind = KIND_EMIT;
      end
    endcase
  end

endmodule

FILE: sv/gnva_queue.sv
// short command fifo between front and back
module gnva_queue import gnva_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             not_empty,
  output logic             full
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;

  assign head      = slots[rd_ptr];
  assign not_empty = (fill != '0);
  assign full      = (fill == CW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: sv/gnva_back.sv
// back end: store read-modify-write, serial divider and clearing sweep
module gnva_back import gnva_pkg::*; #(
  parameter int GROUPS = DEF_GROUPS,
  parameter int NODES  = DEF_NODES,
  parameter int AW     = $clog2(GROUPS * NODES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  cmd_t             q_cmd,
  input  logic [AW-1:0]    q_addr,
  output logic             q_pop,
  output logic             init_busy,
  output logic             done,
  output logic [VAL_W-1:0] avg_value,
  output logic [1:0]       status
);

  localparam int DEPTH = GROUPS * NODES;
  localparam int SW    = $clog2(SUM_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MEM,
    S_DIV,
    S_FIN,
    S_SWEEP
  } state_t;

  state_t             state;
  cmd_t               cur;
  logic [AW-1:0]      cur_addr;
  logic [AW-1:0]      sweep_addr;
  logic               init;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata;
  logic [SUM_W-1:0]   rd_sum;
  logic [CNT_W-1:0]   rd_cnt;
  logic [SUM_W-1:0]   sum_new;
  logic [SUM_W-1:0]   mag;

  // divider
  logic [SUM_W-1:0]   dq;
  logic [CNT_W-1:0]   rem;
  logic [CNT_W-1:0]   divisor;
  logic [SW-1:0]      step;
  logic               neg;
  logic               sat;
  logic [CNT_W:0]     rem_sh;
  logic [CNT_W:0]     rem_sub;
  logic               ge;
  logic [VAL_W-1:0]   quot;

  gnva_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (q_addr),
    .rdata (rdata)
  );

  assign rd_sum  = rdata[CNT_W +: SUM_W];
  assign rd_cnt  = rdata[CNT_W-1:0];
  assign sum_new = rd_sum + {{(SUM_W-VAL_W){cur.value[VAL_W-1]}}, cur.value};
  assign mag     = rd_sum[SUM_W-1] ? (~rd_sum + 1'b1) : rd_sum;

  assign rem_sh  = {rem, dq[SUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, divisor});
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign quot    = dq[VAL_W-1:0];

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign init_busy = init;

  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = '0;
    unique case (state)
      S_MEM: begin
        if (cur.kind == KIND_ACCUM && rd_cnt != COUNT_MAX) begin
          we    = 1'b1;
          wdata = {sum_new, rd_cnt + 1'b1};
        end
      end
      S_SWEEP: begin
        we    = 1'b1;
        waddr = sweep_addr;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      init       <= 1'b1;
      sweep_addr <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur      <= q_cmd;
            cur_addr <= q_addr;
            unique case (q_cmd.kind)
              KIND_EMIT: begin
                done      <= 1'b1;
                avg_value <= q_cmd.value;
                status    <= q_cmd.status;
              end
              KIND_CLEAR: begin
                sweep_addr <= '0;
                state      <= S_SWEEP;
              end
              KIND_ACCUM, KIND_READ: begin
                state <= S_MEM;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_MEM: begin
          if (cur.kind == KIND_ACCUM) begin
            done      <= 1'b1;
            avg_value <= '0;
            status    <= (rd_cnt == COUNT_MAX) ? STAT_SAT : STAT_OK;
            state     <= S_IDLE;
          end else if (rd_cnt == '0) begin
            done      <= 1'b1;
            avg_value <= '0;
            status    <= STAT_OK;
            state     <= S_IDLE;
          end else begin
            dq      <= mag;
            rem     <= '0;
            divisor <= rd_cnt;
            step    <= '0;
            neg     <= rd_sum[SUM_W-1];
            sat     <= (rd_cnt == COUNT_MAX);
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
          dq   <= {dq[SUM_W-2:0], ge};
          step <= step + 1'b1;
          if (step == SW'(SUM_W - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          done      <= 1'b1;
          avg_value <= neg ? (~quot + 1'b1) : quot;
          status    <= sat ? STAT_SAT : STAT_OK;
          state     <= S_IDLE;
        end
        S_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
            init  <= 1'b0;
            if (!init) begin
              done      <= 1'b1;
              avg_value <= '0;
              status    <= STAT_OK;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/grouped_nodal_value_averager_top.sv
// top level of the grouped nodal value averager
//
// keeps a running sum and attachment count per (material group, node) and
// serves accumulate, read-average and clear requests, one result beat per
// request, always in request order. a request is taken when start is high
// and busy is low; its result appears on avg_value/status for exactly one
// cycle with done high and cannot be held off by the receiver. the front
// end decodes each request (filtering, range check, store address) and
// drops it into a two-entry queue, so start may be accepted while the back
// end is still working. the back end owns one store memory with a
// registered read: an accumulate is a read-modify-write of the store, a
// read is a store read, then the bit-serial divider (one quotient bit per
// cycle over the 40-bit sum) and then a final step to apply the sign, and
// filtered, out-of-range or unused requests give their result directly. a
// clear walks the whole store one entry per cycle after the cycle that
// takes it and gives its result beat when the sweep ends. after reset the
// same sweep runs once with busy held high until it ends. only_active is
// to be written through cfg_we/cfg_data while the block is idle; the block
// itself does not enforce this.
module grouped_nodal_value_averager_top import gnva_pkg::*; #(
  parameter int GROUPS = DEF_GROUPS,
  parameter int NODES  = DEF_NODES
) (
  input  logic             clk,
  input  logic             rst,
  // configuration
  input  logic             cfg_we,
  input  logic             cfg_data,
  // request side
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       req_type,
  input  logic [7:0]       group_index,
  input  logic [15:0]      node_index,
  input  logic [VAL_W-1:0] entry_value,
  input  logic             entry_active,
  // result side
  output logic             done,
  output logic [VAL_W-1:0] avg_value,
  output logic [1:0]       status
);

  localparam int AW = $clog2(GROUPS * NODES);
  localparam int QW = $bits(cmd_t) + AW;

  cmd_t          f_cmd;
  logic [AW-1:0] f_addr;
  logic          push;
  logic [QW-1:0] q_head;
  logic          q_valid;
  logic          q_full;
  logic          q_pop;
  logic          init_busy;

  // request beat accepted
  assign push = start && !busy;
  // hold requests off while the queue is full or the power-up sweep runs
  assign busy = q_full || init_busy;

  gnva_front #(
    .GROUPS (GROUPS),
    .NODES  (NODES),
    .AW     (AW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .req_type     (req_type),
    .group_index  (group_index),
    .node_index   (node_index),
    .entry_value  (entry_value),
    .entry_active (entry_active),
    .cmd          (f_cmd),
    .cmd_addr     (f_addr)
  );

  // decoded command plus store address travel together
  gnva_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({f_cmd, f_addr}),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_valid),
    .full      (q_full)
  );

  gnva_back #(
    .GROUPS (GROUPS),
    .NODES  (NODES),
    .AW     (AW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_head[QW-1:AW]),
    .q_addr    (q_head[AW-1:0]),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .done      (done),
    .avg_value (avg_value),
    .status    (status)
  );

endmodule
